@@ src/tld_pkg.sv @@
// Types and constants shared by the terminal line discipline blocks.
// No dependencies; every other file in src uses this package.
`timescale 1ns / 1ps

package tld_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_DEL = 8'h7f;
    localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;

    // Request kinds and result channels
    localparam logic KIND_RX = 1'b0;
    localparam logic KIND_TX = 1'b1;
    localparam logic CHANNEL_TERM = 1'b0;
    localparam logic CHANNEL_LINE = 1'b1;

    // Line length limit after reset
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 6'd32;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_in;
    } item_t;

    typedef struct packed {
        logic              channel;
        logic [BYTE_W-1:0] data_out;
        logic              last;
        logic [LEN_W-1:0]  line_length;
    } result_t;

    // Echo sequences the back end knows how to play
    typedef enum logic [1:0] {
        OP_ECHO,
        OP_CRLF,
        OP_RUBOUT
    } op_t;

    // One queued command from front to back
    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
        logic              deliver;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ECHO,
        BK_LINE
    } back_state_t;

endpackage

@@ src/tld_front.sv @@
// Front end: accepts requests, edits the line store and fill count,
// and queues echo/delivery commands. Depends on tld_pkg.
`timescale 1ns / 1ps

module tld_front #(
    parameter int LINE_MAX = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  tld_pkg::item_t            item,
    input  logic                      cfg_we,
    input  logic [tld_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                      q_full,
    output logic                      push,
    output tld_pkg::cmd_t             push_cmd,
    output logic                      wr_en,
    output logic [$clog2(LINE_MAX)-1:0] wr_addr,
    output logic [tld_pkg::BYTE_W-1:0] wr_data,
    input  logic                      line_done,
    output logic                      line_busy
);

    localparam int AW = $clog2(LINE_MAX);
    localparam int FW = $clog2(LINE_MAX + 1);

    logic [tld_pkg::LEN_W-1:0] max_len_reg;
    logic [FW-1:0]             fill_reg, fill_next;
    logic                      busy_reg, busy_next;
    logic [tld_pkg::LEN_W-1:0] limit;
    logic [FW-1:0]             fill_inc;
    logic                      accept;

    // Hold off while the queue is full or a line is being read out
    assign item_stall = q_full | busy_reg;
    assign accept     = item_valid & ~item_stall;
    assign line_busy  = busy_reg;
    assign fill_inc   = fill_reg + FW'(1);

    // Clamp the length limit to 1..LINE_MAX
    always_comb
    begin
        if (max_len_reg == '0)
        begin
            limit = tld_pkg::LEN_W'(1);
        end
        else if (max_len_reg > tld_pkg::LEN_W'(LINE_MAX))
        begin
            limit = tld_pkg::LEN_W'(LINE_MAX);
        end
        else
        begin
            limit = max_len_reg;
        end
    end

    // Classify the request and edit the line
    always_comb
    begin
        push             = 1'b0;
        push_cmd.op      = tld_pkg::OP_ECHO;
        push_cmd.data    = item.data_in;
        push_cmd.deliver = 1'b0;
        push_cmd.len     = tld_pkg::LEN_W'(fill_inc);
        wr_en            = 1'b0;
        wr_addr          = fill_reg[AW-1:0];
        wr_data          = item.data_in;
        fill_next        = fill_reg;
        busy_next        = line_done ? 1'b0 : busy_reg;

        if (accept)
        begin
            case (item.kind)
                tld_pkg::KIND_TX:
                begin
                    push = 1'b1;
                    if (item.data_in == tld_pkg::CH_LF)
                    begin
                        push_cmd.op = tld_pkg::OP_CRLF;
                    end
                end
                tld_pkg::KIND_RX:
                begin
                    if (item.data_in == tld_pkg::CH_CR || item.data_in == tld_pkg::CH_LF)
                    begin
                        // newline: store LF and hand the line over
                        push             = 1'b1;
                        push_cmd.op      = tld_pkg::OP_CRLF;
                        push_cmd.data    = tld_pkg::CH_LF;
                        push_cmd.deliver = 1'b1;
                        wr_en            = 1'b1;
                        wr_data          = tld_pkg::CH_LF;
                        fill_next        = '0;
                        busy_next        = 1'b1;
                    end
                    else if (item.data_in == tld_pkg::CH_DEL)
                    begin
                        // rubout only when there is something to remove
                        if (fill_reg != '0)
                        begin
                            push        = 1'b1;
                            push_cmd.op = tld_pkg::OP_RUBOUT;
                            fill_next   = fill_reg - FW'(1);
                        end
                    end
                    else
                    begin
                        push  = 1'b1;
                        wr_en = 1'b1;
                        if (tld_pkg::LEN_W'(fill_inc) >= limit)
                        begin
                            push_cmd.deliver = 1'b1;
                            fill_next        = '0;
                            busy_next        = 1'b1;
                        end
                        else
                        begin
                            fill_next = fill_inc;
                        end
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= tld_pkg::MAX_LEN_RESET;
            fill_reg    <= '0;
            busy_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
            fill_reg <= fill_next;
            busy_reg <= busy_next;
        end
    end

endmodule

@@ src/tld_queue.sv @@
// Two-entry command queue between front and back end.
// Depends on tld_pkg for the command type.
`timescale 1ns / 1ps

module tld_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tld_pkg::cmd_t push_cmd,
    input  logic          pop,
    output tld_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    tld_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    // Entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/tld_back.sv @@
// Back end: plays echo sequences and reads delivered lines out of the
// line store into the result register. Depends on tld_pkg.
`timescale 1ns / 1ps

module tld_back #(
    parameter int LINE_MAX = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    output logic                        pop,
    input  tld_pkg::cmd_t               head,
    input  logic                        wr_en,
    input  logic [$clog2(LINE_MAX)-1:0] wr_addr,
    input  logic [tld_pkg::BYTE_W-1:0]  wr_data,
    output logic                        result_valid,
    input  logic                        result_stall,
    output tld_pkg::result_t            result,
    output logic                        line_done
);

    localparam int AW = $clog2(LINE_MAX);

    tld_pkg::back_state_t       state_reg, state_next;
    tld_pkg::cmd_t              cmd_reg;
    logic [1:0]                 step_reg, step_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic [tld_pkg::BYTE_W-1:0] line_mem [LINE_MAX];
    logic [tld_pkg::BYTE_W-1:0] rd_data_reg;
    logic                       out_valid_reg, out_valid_next;
    tld_pkg::result_t           out_reg, load_item;
    logic                       load, load_ok;
    logic [tld_pkg::BYTE_W-1:0] echo_byte;
    logic                       echo_final, line_final;

    assign load_ok      = ~out_valid_reg | ~result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign pop          = (state_reg == tld_pkg::BK_IDLE) & ~q_empty;
    assign line_final   = (tld_pkg::LEN_W'(idx_reg) == cmd_reg.len - tld_pkg::LEN_W'(1));

    // Echo byte for the current step
    always_comb
    begin
        echo_byte  = cmd_reg.data;
        echo_final = 1'b1;
        case (cmd_reg.op)
            tld_pkg::OP_ECHO:
            begin
                echo_byte  = cmd_reg.data;
                echo_final = 1'b1;
            end
            tld_pkg::OP_CRLF:
            begin
                echo_byte  = (step_reg == 2'd0) ? tld_pkg::CH_CR : cmd_reg.data;
                echo_final = (step_reg != 2'd0);
            end
            tld_pkg::OP_RUBOUT:
            begin
                echo_byte  = (step_reg == 2'd1) ? tld_pkg::CH_SP : tld_pkg::CH_BS;
                echo_final = (step_reg == 2'd2);
            end
            default:
            begin
                echo_byte  = cmd_reg.data;
                echo_final = 1'b1;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tld_pkg::BK_IDLE:
            begin
                if (pop)
                begin
                    state_next = tld_pkg::BK_ECHO;
                end
            end
            tld_pkg::BK_ECHO:
            begin
                if (load_ok && echo_final)
                begin
                    state_next = cmd_reg.deliver ? tld_pkg::BK_LINE : tld_pkg::BK_IDLE;
                end
            end
            tld_pkg::BK_LINE:
            begin
                if (load_ok && line_final)
                begin
                    state_next = tld_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = tld_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs of each state
    always_comb
    begin
        load                  = 1'b0;
        load_item.channel     = tld_pkg::CHANNEL_TERM;
        load_item.data_out    = echo_byte;
        load_item.last        = 1'b0;
        load_item.line_length = '0;
        step_next             = '0;
        idx_next              = '0;
        line_done             = 1'b0;
        case (state_reg)
            tld_pkg::BK_IDLE:
            begin
                step_next = '0;
            end
            tld_pkg::BK_ECHO:
            begin
                step_next = step_reg;
                if (load_ok)
                begin
                    load           = 1'b1;
                    load_item.last = echo_final & ~cmd_reg.deliver;
                    step_next      = step_reg + 2'd1;
                end
            end
            tld_pkg::BK_LINE:
            begin
                idx_next              = idx_reg;
                load_item.channel     = tld_pkg::CHANNEL_LINE;
                load_item.data_out    = rd_data_reg;
                load_item.last        = line_final;
                load_item.line_length = cmd_reg.len;
                if (load_ok)
                begin
                    load      = 1'b1;
                    line_done = line_final;
                    idx_next  = line_final ? '0 : idx_reg + AW'(1);
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase
        out_valid_next = load | (out_valid_reg & result_stall);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tld_pkg::BK_IDLE;
            step_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
        if (load)
        begin
            out_reg <= load_item;
        end
    end

    // Line store: one write port, registered read that tracks the next index
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= line_mem[idx_next];
    end

endmodule

@@ src/terminal_line_discipline_core.sv @@
// Top level of the terminal line discipline: front end, command queue
// and back end. Depends on tld_pkg, tld_front, tld_queue, tld_back.
//
// Usage:
//   Request channel (item_valid / item_stall / item): kind 0 is a byte
//   received from the terminal, kind 1 a byte to send to it.
//   Result channel (result_valid / result_stall / result): echo and
//   transmit bytes on channel 0, delivered line bytes on channel 1, with
//   last set on the final result of each request.
//   cfg_we / cfg_wdata write the maximum line length (clamped 1..LINE_MAX).
// Timing:
//   A request is taken and queued; its first result passes through the queue
//   entry and the back end's command register into the result register.
//   While result_stall is low, echo gives one byte per cycle (1 to 3) and a
//   delivered line one line byte per cycle from the single line store read port.
//   While a line is being read out, item_stall stays high.
//   A DEL on an empty line gives no result.
// Reset clears the line (fill count zero), empties the queue and sets
// the length limit to 32. While result_stall is high the result register
// holds; the queue keeps taking requests until it fills.
`timescale 1ns / 1ps

module terminal_line_discipline_core #(
    parameter int LINE_MAX = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  tld_pkg::item_t            item,
    output logic                      result_valid,
    input  logic                      result_stall,
    output tld_pkg::result_t          result,
    input  logic                      cfg_we,
    input  logic [tld_pkg::LEN_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(LINE_MAX);

    logic                       q_full, q_empty, push, pop;
    tld_pkg::cmd_t              push_cmd, head;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [tld_pkg::BYTE_W-1:0] wr_data;
    logic                       line_done, line_busy;

    // Request side
    tld_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .line_done  (line_done),
        .line_busy  (line_busy)
    );

    // Command queue
    tld_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Result side
    tld_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .pop          (pop),
        .head         (head),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .line_done    (line_done)
    );

`ifndef NO_ASSERTIONS
    // Terminal bytes carry no length
    a_term_len: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.channel == tld_pkg::CHANNEL_TERM) |->
            (result.line_length == '0))
        else $error("terminal byte with non-zero length");

    // Line bytes carry a length within the store
    a_line_len: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.channel == tld_pkg::CHANNEL_LINE) |->
            (result.line_length != '0 &&
             result.line_length <= tld_pkg::LEN_W'(LINE_MAX)))
        else $error("line byte with bad length");

    // A line read-out only ends while the front is holding for it
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        line_done |-> line_busy)
        else $error("line read-out ended with no line pending");

    // The front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("command queue overflow");
`endif

endmodule

@@ sim/terminal_line_discipline_checker.sv @@
// Scoreboard for the terminal line discipline: watches the request, result
// and length-register ports, predicts every result and compares in order.
// Depends on tld_pkg.
`timescale 1ns / 1ps

module terminal_line_discipline_checker #(
    parameter int LINE_MAX = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  logic                      item_stall,
    input  tld_pkg::item_t            item,
    input  logic                      result_valid,
    input  logic                      result_stall,
    input  tld_pkg::result_t          result,
    input  logic                      cfg_we,
    input  logic [tld_pkg::LEN_W-1:0] cfg_wdata,
    output int                        fail_count,
    output int                        awaited_count
);

    // Own copy of the editor state
    logic [tld_pkg::BYTE_W-1:0] line_copy [LINE_MAX];
    int                         line_fill;
    logic [tld_pkg::LEN_W-1:0]  len_limit_reg;

    // Bytes still to come from the block, oldest first
    tld_pkg::result_t awaited_bytes [$];
    // Results of the request being worked out
    tld_pkg::result_t burst [$];
    int               mismatches;

    function automatic tld_pkg::result_t term_byte(input logic [tld_pkg::BYTE_W-1:0] b);
        tld_pkg::result_t r;
        r.channel     = tld_pkg::CHANNEL_TERM;
        r.data_out    = b;
        r.last        = 1'b0;
        r.line_length = '0;
        return r;
    endfunction

    function automatic int line_limit();
        int m;
        m = int'(len_limit_reg);
        if (m < 1)
            m = 1;
        if (m > LINE_MAX)
            m = LINE_MAX;
        return m;
    endfunction

    task automatic store_char(input logic [tld_pkg::BYTE_W-1:0] b);
        if (line_fill < LINE_MAX)
        begin
            line_copy[line_fill] = b;
            line_fill++;
        end
    endtask

    // Hand the whole line to the reader and start a fresh one
    task automatic flush_line();
        tld_pkg::result_t r;
        for (int k = 0; k < line_fill; k++)
        begin
            r.channel     = tld_pkg::CHANNEL_LINE;
            r.data_out    = line_copy[k];
            r.last        = 1'b0;
            r.line_length = tld_pkg::LEN_W'(line_fill);
            burst.push_back(r);
        end
        line_fill = 0;
    endtask

    // Echo, edit and delivery for one request
    task automatic echo_and_deliver(input tld_pkg::item_t req);
        burst.delete();
        if (req.kind == tld_pkg::KIND_TX)
        begin
            if (req.data_in == tld_pkg::CH_LF)
                burst.push_back(term_byte(tld_pkg::CH_CR));
            burst.push_back(term_byte(req.data_in));
        end
        else if (req.data_in == tld_pkg::CH_CR || req.data_in == tld_pkg::CH_LF)
        begin
            burst.push_back(term_byte(tld_pkg::CH_CR));
            burst.push_back(term_byte(tld_pkg::CH_LF));
            store_char(tld_pkg::CH_LF);
            flush_line();
        end
        else if (req.data_in == tld_pkg::CH_DEL)
        begin
            // rubout only when there is something to remove
            if (line_fill > 0)
            begin
                burst.push_back(term_byte(tld_pkg::CH_BS));
                burst.push_back(term_byte(tld_pkg::CH_SP));
                burst.push_back(term_byte(tld_pkg::CH_BS));
                line_fill--;
            end
        end
        else
        begin
            burst.push_back(term_byte(req.data_in));
            store_char(req.data_in);
            if (line_fill >= line_limit())
                flush_line();
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[k])
            awaited_bytes.push_back(burst[k]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tld_pkg::result_t want;
        if (!rst_n)
        begin
            line_fill     = 0;
            len_limit_reg = tld_pkg::MAX_LEN_RESET;
            awaited_bytes.delete();
            mismatches    = 0;
            fail_count    <= 0;
            awaited_count <= 0;
        end
        else
        begin
            if (cfg_we)
                len_limit_reg = cfg_wdata;

            if (item_valid && !item_stall)
                echo_and_deliver(item);

            // Compare each taken result with the oldest prediction
            if (result_valid && !result_stall)
            begin
                if (awaited_bytes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result ch=%0d data=%02h last=%0d len=%0d",
                             $time, result.channel, result.data_out, result.last,
                             result.line_length);
                end
                else
                begin
                    want = awaited_bytes.pop_front();
                    if (result.channel !== want.channel
                        || result.data_out !== want.data_out
                        || result.last !== want.last
                        || result.line_length !== want.line_length)
                    begin
                        mismatches++;
                        $display("%0t: mismatch: expected ch=%0d data=%02h last=%0d len=%0d",
                                 $time, want.channel, want.data_out, want.last,
                                 want.line_length);
                        $display("%0t:           actual   ch=%0d data=%02h last=%0d len=%0d",
                                 $time, result.channel, result.data_out, result.last,
                                 result.line_length);
                    end
                end
            end

            fail_count    <= mismatches;
            awaited_count <= awaited_bytes.size();
        end
    end

endmodule

@@ sim/terminal_line_discipline_core_tb.sv @@
// Stimulus and verdict for terminal_line_discipline_core: directed and random
// terminal traffic under varied idling. Depends on tld_pkg, the core and
// terminal_line_discipline_checker.
`timescale 1ns / 1ps

module terminal_line_discipline_core_tb;

    localparam int LINE_MAX       = 32;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_ITEMS    = 90;

    logic                      clk;
    logic                      rst_n;
    logic                      item_valid;
    logic                      item_stall;
    tld_pkg::item_t            item;
    logic                      result_valid;
    logic                      result_stall;
    tld_pkg::result_t          result;
    logic                      cfg_we;
    logic [tld_pkg::LEN_W-1:0] cfg_wdata;

    int fail_count;
    int awaited_count;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_done      = 0;
    int sent           = 0;
    int idle_cycles    = 0;

    terminal_line_discipline_core #(
        .LINE_MAX (LINE_MAX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    terminal_line_discipline_checker #(
        .LINE_MAX (LINE_MAX)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .awaited_count (awaited_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: too long with nothing taken on either channel
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Reader side: random stalls, or a long hold-off when asked
    initial
    begin : reader
        int k;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_done < hold_asked)
            begin
                result_stall <= 1'b1;
                for (k = 1; k < HOLD_CYCLES; k++)
                    @(posedge clk);
                hold_done++;
            end
            else
                result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offer one request and hold it until taken
    task automatic send_request(input logic k, input logic [tld_pkg::BYTE_W-1:0] d);
        tld_pkg::item_t req;
        req.kind    = k;
        req.data_in = d;
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= req;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent++;
    endtask

    // Stop offering and wait until every predicted byte has come out
    task automatic drain_output();
        item_valid <= 1'b0;
        @(posedge clk);
        while (awaited_count != 0)
            @(posedge clk);
    endtask

    // Length register may only change with the block quiet
    task automatic write_max_len(input logic [tld_pkg::LEN_W-1:0] v);
        drain_output();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Any byte that the editor simply stores
    function automatic logic [tld_pkg::BYTE_W-1:0] plain_byte();
        logic [tld_pkg::BYTE_W-1:0] b;
        do
            b = tld_pkg::BYTE_W'($urandom_range(255));
        while (b == tld_pkg::CH_CR || b == tld_pkg::CH_LF || b == tld_pkg::CH_DEL);
        return b;
    endfunction

    // A typed line with rubouts and interleaved transmit bytes, then newline
    task automatic type_line();
        int len;
        int k;
        int r;
        len = ($urandom_range(3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
        for (k = 0; k < len; k++)
        begin
            r = $urandom_range(99);
            if (r < 10)
                send_request(tld_pkg::KIND_RX, tld_pkg::CH_DEL);
            else if (r < 13)
                send_request(tld_pkg::KIND_TX, tld_pkg::CH_LF);
            else if (r < 18)
                send_request(tld_pkg::KIND_TX, tld_pkg::BYTE_W'($urandom_range(255)));
            else
                send_request(tld_pkg::KIND_RX, plain_byte());
        end
        send_request(tld_pkg::KIND_RX, $urandom_range(1) ? tld_pkg::CH_CR : tld_pkg::CH_LF);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_request(1'($urandom_range(1)), tld_pkg::BYTE_W'($urandom_range(255)));
    endtask

    task automatic run_traffic(input int n);
        int goal;
        goal = sent + n;
        while (sent < goal)
        begin
            if ($urandom_range(99) < 80)
                type_line();
            else
                send_noise();
        end
    endtask

    initial
    begin
        int w;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, rubout down past an empty line
        send_request(tld_pkg::KIND_RX, 8'h61);
        send_request(tld_pkg::KIND_RX, 8'h00);
        send_request(tld_pkg::KIND_RX, 8'hff);
        send_request(tld_pkg::KIND_RX, 8'h80);
        repeat (5) send_request(tld_pkg::KIND_RX, tld_pkg::CH_DEL);
        // newline on an empty line, then LF as terminator
        send_request(tld_pkg::KIND_RX, tld_pkg::CH_CR);
        send_request(tld_pkg::KIND_RX, 8'h7e);
        send_request(tld_pkg::KIND_RX, tld_pkg::CH_LF);
        // transmit path, LF expanded
        send_request(tld_pkg::KIND_TX, tld_pkg::CH_LF);
        send_request(tld_pkg::KIND_TX, 8'h00);
        send_request(tld_pkg::KIND_TX, 8'hff);
        send_request(tld_pkg::KIND_TX, tld_pkg::CH_DEL);
        send_request(tld_pkg::KIND_TX, tld_pkg::CH_CR);
        // limit lowered below the current fill: next byte delivers at once
        repeat (6) send_request(tld_pkg::KIND_RX, plain_byte());
        write_max_len(6'd3);
        send_request(tld_pkg::KIND_RX, 8'h41);

        // Sender mostly busy, reader mostly stalling; limit clamps to the maximum
        write_max_len(6'd63);
        send_gap_pct   = 9;
        recv_stall_pct = 76;
        run_traffic(PHASE_ITEMS / 2);
        drain_output();
        run_traffic(PHASE_ITEMS / 2);

        // Sender sparse, reader eager; zero acts as one, then one
        write_max_len(6'd0);
        send_gap_pct   = 76;
        recv_stall_pct = 9;
        run_traffic(PHASE_ITEMS / 2);
        write_max_len(6'd1);
        run_traffic(PHASE_ITEMS / 2);

        // Full rate, opening with a long reader hold-off to fill the queue
        write_max_len(6'd12);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_asked     = 1;
        run_traffic(PHASE_ITEMS / 2);
        write_max_len(6'd32);
        run_traffic(PHASE_ITEMS / 2);

        // Let the block empty out, bounded
        item_valid <= 1'b0;
        for (w = 0; w < 20000 && awaited_count != 0; w++)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (awaited_count != 0)
            $display("%0t: %0d predicted results never arrived", $time, awaited_count);
        if (fail_count == 0 && awaited_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
src/tld_pkg.sv
src/tld_front.sv
src/tld_queue.sv
src/tld_back.sv
src/terminal_line_discipline_core.sv
sim/terminal_line_discipline_checker.sv
sim/terminal_line_discipline_core_tb.sv
